[src/cps_pkg.sv]
// Shared types and constants for the periodic CAN frame scheduler.
// No dependencies.
package cps_pkg;

    localparam int SLOTS      = 4;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_OUT    = 4;
    localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
    localparam int STEP_W     = 10;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd10;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SLOT  = 1'b1;

    typedef enum logic [1:0] {
        OP_START,
        OP_STOP,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t          op;
        logic [28:0]  id;
        logic         ext;
        logic [3:0]   len;
        logic [63:0]  payload;
        logic [31:0]  period;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [1:0] slot_code(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+1:0] t;
        t = {2'b00, s};
        return t[1:0];
    endfunction

endpackage

[src/cps_front.sv]
// Front end: accepts request transactions, decodes the request type and
// queues commands for the back end. Depends on cps_pkg.
module cps_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     req_type,
    input  logic [28:0]    frame_id,
    input  logic           extended,
    input  logic [3:0]     length_code,
    input  logic [63:0]    payload,
    input  logic [31:0]    repeat_period,
    output logic           busy,
    input  logic           deq,
    output cps_pkg::cmd_t  head,
    output cps_pkg::qstat_t qstat
);
    import cps_pkg::*;

    cmd_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              push;
    cmd_t              cmd_in;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign busy        = qstat.full;
    assign accept      = start && !busy;
    assign head        = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.id      = frame_id;
        cmd_in.ext     = extended;
        cmd_in.len     = length_code;
        cmd_in.payload = payload;
        cmd_in.period  = repeat_period;
        cmd_in.op      = OP_START;
        push           = accept;
        unique case (req_type)
            REQ_START: cmd_in.op = OP_START;
            REQ_STOP:  cmd_in.op = OP_STOP;
            REQ_TICK:  cmd_in.op = OP_TICK;
            default:   push = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[src/cps_back.sv]
// Back end: slot table, millisecond clock and the per-slot sequencer that
// executes queued commands and emits results. Depends on cps_pkg.
module cps_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [cps_pkg::STEP_W-1:0] step,
    input  cps_pkg::cmd_t              head,
    input  cps_pkg::qstat_t            qstat,
    output logic                       deq,
    output logic                       result_valid,
    output logic                       result_kind,
    output logic                       status,
    output logic [28:0]                out_id,
    output logic                       out_extended,
    output logic [3:0]                 out_length,
    output logic [63:0]                out_payload,
    output logic [1:0]                 out_slot,
    output logic                       last
);
    import cps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STOP,
        S_TICK,
        S_FLUSH
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 free_vld_reg, free_vld_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          clock_reg, clock_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [28:0]          pend_id_reg, pend_id_next;
    logic                 pend_ext_reg, pend_ext_next;
    logic [3:0]           pend_len_reg, pend_len_next;
    logic [63:0]          pend_pay_reg, pend_pay_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;

    logic                 res_v_reg, res_v_next;
    logic                 res_kind_reg, res_kind_next;
    logic                 res_st_reg, res_st_next;
    logic [28:0]          res_id_reg, res_id_next;
    logic                 res_ext_reg, res_ext_next;
    logic [3:0]           res_len_reg, res_len_next;
    logic [63:0]          res_pay_reg, res_pay_next;
    logic [1:0]           res_slot_reg, res_slot_next;
    logic                 res_last_reg, res_last_next;

    logic                 active_reg [SLOTS];
    logic [28:0]          ident_reg [SLOTS];
    logic                 ext_reg [SLOTS];
    logic [3:0]           len_reg [SLOTS];
    logic [63:0]          pay_reg [SLOTS];
    logic [31:0]          period_reg [SLOTS];
    logic [31:0]          sent_reg [SLOTS];

    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_sel;
    logic                 clr_en;
    logic                 sent_en;
    logic                 cur_active;
    logic                 id_hit;
    logic                 at_end;
    logic [31:0]          elapsed;
    logic                 due;
    logic                 fv;
    logic [SLOT_W-1:0]    fi;

    assign cur_active = active_reg[idx_reg];
    assign id_hit     = cur_active && (ident_reg[idx_reg] == cmd_reg.id);
    assign at_end     = (idx_reg == SLOT_W'(SLOTS - 1));
    assign elapsed    = clock_reg - sent_reg[idx_reg];
    assign due        = cur_active && (elapsed >= period_reg[idx_reg]);
    assign fv         = free_vld_reg || !cur_active;
    assign fi         = free_vld_reg ? free_idx_reg : idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        cnt_next       = cnt_reg;
        clock_next     = clock_reg;
        pend_vld_next  = pend_vld_reg;
        pend_id_next   = pend_id_reg;
        pend_ext_next  = pend_ext_reg;
        pend_len_next  = pend_len_reg;
        pend_pay_next  = pend_pay_reg;
        pend_slot_next = pend_slot_reg;
        res_v_next     = 1'b0;
        res_kind_next  = KIND_STATUS;
        res_st_next    = ST_OK;
        res_id_next    = '0;
        res_ext_next   = 1'b0;
        res_len_next   = '0;
        res_pay_next   = '0;
        res_slot_next  = '0;
        res_last_next  = 1'b0;
        deq            = 1'b0;
        wr_en          = 1'b0;
        wr_sel         = idx_reg;
        clr_en         = 1'b0;
        sent_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    deq           = 1'b1;
                    cmd_next      = head;
                    idx_next      = '0;
                    free_vld_next = 1'b0;
                    cnt_next      = '0;
                    pend_vld_next = 1'b0;
                    unique case (head.op)
                        OP_START: state_next = S_START;
                        OP_STOP:  state_next = S_STOP;
                        OP_TICK:
                        begin
                            clock_next = clock_reg + 32'(step);
                            state_next = S_TICK;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_START:
            begin
                if (id_hit)
                begin
                    wr_en         = 1'b1;
                    wr_sel        = idx_reg;
                    res_v_next    = 1'b1;
                    res_slot_next = slot_code(idx_reg);
                    res_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (at_end)
                begin
                    res_v_next    = 1'b1;
                    res_last_next = 1'b1;
                    if (fv)
                    begin
                        wr_en         = 1'b1;
                        wr_sel        = fi;
                        res_slot_next = slot_code(fi);
                    end
                    else
                    begin
                        res_st_next = ST_NO_SLOT;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    free_vld_next = fv;
                    free_idx_next = fi;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            S_STOP:
            begin
                clr_en = id_hit;
                if (at_end)
                begin
                    res_v_next    = 1'b1;
                    res_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TICK:
            begin
                if (due && (cnt_reg < OUT_CNT_W'(MAX_OUT)))
                begin
                    sent_en = 1'b1;
                    if (pend_vld_reg)
                    begin
                        res_v_next    = 1'b1;
                        res_kind_next = KIND_FRAME;
                        res_id_next   = pend_id_reg;
                        res_ext_next  = pend_ext_reg;
                        res_len_next  = pend_len_reg;
                        res_pay_next  = pend_pay_reg;
                        res_slot_next = slot_code(pend_slot_reg);
                    end
                    pend_vld_next  = 1'b1;
                    pend_id_next   = ident_reg[idx_reg];
                    pend_ext_next  = ext_reg[idx_reg];
                    pend_len_next  = len_reg[idx_reg];
                    pend_pay_next  = pay_reg[idx_reg];
                    pend_slot_next = idx_reg;
                    cnt_next       = cnt_reg + 1'b1;
                end
                if (at_end)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    res_v_next    = 1'b1;
                    res_kind_next = KIND_FRAME;
                    res_id_next   = pend_id_reg;
                    res_ext_next  = pend_ext_reg;
                    res_len_next  = pend_len_reg;
                    res_pay_next  = pend_pay_reg;
                    res_slot_next = slot_code(pend_slot_reg);
                    res_last_next = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            res_v_reg     <= 1'b0;
            res_kind_reg  <= KIND_STATUS;
            res_st_reg    <= ST_OK;
            res_id_reg    <= '0;
            res_ext_reg   <= 1'b0;
            res_len_reg   <= '0;
            res_pay_reg   <= '0;
            res_slot_reg  <= '0;
            res_last_reg  <= 1'b0;
            idx_reg       <= '0;
            free_vld_reg  <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                active_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clock_reg    <= clock_next;
            pend_vld_reg <= pend_vld_next;
            res_v_reg    <= res_v_next;
            res_kind_reg <= res_kind_next;
            res_st_reg   <= res_st_next;
            res_id_reg   <= res_id_next;
            res_ext_reg  <= res_ext_next;
            res_len_reg  <= res_len_next;
            res_pay_reg  <= res_pay_next;
            res_slot_reg <= res_slot_next;
            res_last_reg <= res_last_next;
            idx_reg      <= idx_next;
            free_vld_reg <= free_vld_next;
            cnt_reg      <= cnt_next;
            if (wr_en)
            begin
                active_reg[wr_sel] <= 1'b1;
            end
            if (clr_en)
            begin
                active_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        free_idx_reg   <= free_idx_next;
        pend_id_reg    <= pend_id_next;
        pend_ext_reg   <= pend_ext_next;
        pend_len_reg   <= pend_len_next;
        pend_pay_reg   <= pend_pay_next;
        pend_slot_reg  <= pend_slot_next;
        if (wr_en)
        begin
            ident_reg[wr_sel]  <= cmd_reg.id;
            ext_reg[wr_sel]    <= cmd_reg.ext;
            len_reg[wr_sel]    <= cmd_reg.len;
            pay_reg[wr_sel]    <= cmd_reg.payload;
            period_reg[wr_sel] <= cmd_reg.period;
            sent_reg[wr_sel]   <= '0;
        end
        else if (sent_en)
        begin
            sent_reg[idx_reg] <= clock_reg;
        end
    end

    assign result_valid = res_v_reg;
    assign result_kind  = res_kind_reg;
    assign status       = res_st_reg;
    assign out_id       = res_id_reg;
    assign out_extended = res_ext_reg;
    assign out_length   = res_len_reg;
    assign out_payload  = res_pay_reg;
    assign out_slot     = res_slot_reg;
    assign last         = res_last_reg;

endmodule

[src/can_periodic_frame_scheduler_top.sv]
// Top level of the periodic CAN frame scheduler: step register, front end
// queue and back end sequencer. Depends on cps_pkg, cps_front, cps_back.
//
// Usage:
//   Requests are presented on req_type and the frame fields with start; a
//   transaction is taken at a clock edge where start is high and busy is low.
//   busy is high only while the two-entry command queue is full.
//   Type 0 starts a periodic frame, type 1 stops one, type 2 is a time tick;
//   type 3 is taken and dropped.
//   Results appear for one cycle each, marked by result_valid, with last set
//   on the final result of a request. The receiver cannot stall them.
//   The back end visits one slot per cycle. A start or stop gives its
//   status when its scan of the slots ends (a start whose id matches a
//   slot ends there); a tick gives its final frame after its scan, earlier
//   due frames leaving as the scan finds the next due slot.
//   cfg_we writes cfg_wdata into the tick step; write it only while idle.
//   Reset clears the slot active flags, the millisecond clock and the queue,
//   and sets the tick step to 10 ms. No clearing pass is needed.
module can_periodic_frame_scheduler_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 req_type,
    input  logic [28:0]                frame_id,
    input  logic                       extended,
    input  logic [3:0]                 length_code,
    input  logic [63:0]                payload,
    input  logic [31:0]                repeat_period,
    input  logic                       cfg_we,
    input  logic [cps_pkg::STEP_W-1:0] cfg_wdata,
    output logic                       result_valid,
    output logic                       result_kind,
    output logic                       status,
    output logic [28:0]                out_id,
    output logic                       out_extended,
    output logic [3:0]                 out_length,
    output logic [63:0]                out_payload,
    output logic [1:0]                 out_slot,
    output logic                       last
);
    import cps_pkg::*;

    logic [STEP_W-1:0] step_reg;
    cmd_t              head;
    qstat_t            qstat;
    logic              deq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    cps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .frame_id      (frame_id),
        .extended      (extended),
        .length_code   (length_code),
        .payload       (payload),
        .repeat_period (repeat_period),
        .busy          (busy),
        .deq           (deq),
        .head          (head),
        .qstat         (qstat)
    );

    cps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step_reg),
        .head         (head),
        .qstat        (qstat),
        .deq          (deq),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .status       (status),
        .out_id       (out_id),
        .out_extended (out_extended),
        .out_length   (out_length),
        .out_payload  (out_payload),
        .out_slot     (out_slot),
        .last         (last)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> !deq)
        else $error("pop from empty command queue");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_STATUS) |-> last)
        else $error("status transaction not marked last");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_NO_SLOT) |->
            (result_kind == KIND_STATUS && out_slot == 2'd0))
        else $error("no-slot status malformed");

    a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_FRAME) |-> (status == ST_OK))
        else $error("frame transaction carries error status");

endmodule

[sim/testbench.sv]
// Self-checking testbench for can_periodic_frame_scheduler_top.
// Tracks its own slot table, millisecond clock and tick step to predict every
// status and frame; depends on cps_pkg and the scheduler RTL.
module testbench;
    import cps_pkg::*;

    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [28:0] ID_MAX       = 29'h1FFF_FFFF;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          POOL_SIZE    = 6;

    typedef struct packed {
        logic        kind;
        logic        status;
        logic [28:0] id;
        logic        ext;
        logic [3:0]  len;
        logic [63:0] payload;
        logic [1:0]  slot;
        logic        last;
    } sched_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic [1:0]        req_type      = REQ_TICK;
    logic [28:0]       frame_id      = '0;
    logic              extended      = 1'b0;
    logic [3:0]        length_code   = '0;
    logic [63:0]       payload       = '0;
    logic [31:0]       repeat_period = '0;
    logic              cfg_we        = 1'b0;
    logic [STEP_W-1:0] cfg_wdata     = STEP_RESET;
    logic              busy;
    logic              result_valid;
    logic              result_kind;
    logic              status;
    logic [28:0]       out_id;
    logic              out_extended;
    logic [3:0]        out_length;
    logic [63:0]       out_payload;
    logic [1:0]        out_slot;
    logic              last;

    logic              slot_on   [SLOTS];
    logic [28:0]       slot_id   [SLOTS];
    logic              slot_ext  [SLOTS];
    logic [3:0]        slot_len  [SLOTS];
    logic [63:0]       slot_pay  [SLOTS];
    logic [31:0]       slot_per  [SLOTS];
    logic [31:0]       slot_sent [SLOTS];
    logic [31:0]       now_ms;
    logic [STEP_W-1:0] step_ms;
    sched_result_t     owed_results[$];
    sched_result_t     head;
    logic [28:0]       id_pool [POOL_SIZE];
    int                mismatches   = 0;
    int                burst_left   = 0;
    int                quiet_cycles = 0;

    can_periodic_frame_scheduler_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .frame_id      (frame_id),
        .extended      (extended),
        .length_code   (length_code),
        .payload       (payload),
        .repeat_period (repeat_period),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .status        (status),
        .out_id        (out_id),
        .out_extended  (out_extended),
        .out_length    (out_length),
        .out_payload   (out_payload),
        .out_slot      (out_slot),
        .last          (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic schedule_request(input logic [1:0] req, input logic [28:0] id,
                                    input logic ext, input logic [3:0] len,
                                    input logic [63:0] pay, input logic [31:0] period);
        sched_result_t r;
        sched_result_t batch [MAX_OUT];
        logic [31:0]   elapsed;
        int            n;
        int            hit;
        r   = '0;
        n   = 0;
        hit = -1;
        case (req)
            REQ_START:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_on[i] && slot_id[i] == id)
                        hit = i;
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && !slot_on[i])
                        hit = i;
                r.kind = KIND_STATUS;
                if (hit < 0)
                    r.status = ST_NO_SLOT;
                else
                begin
                    slot_on[hit]   = 1'b1;
                    slot_id[hit]   = id;
                    slot_ext[hit]  = ext;
                    slot_len[hit]  = len;
                    slot_pay[hit]  = pay;
                    slot_per[hit]  = period;
                    slot_sent[hit] = '0;
                    r.status       = ST_OK;
                    r.slot         = 2'(hit);
                end
                r.last = 1'b1;
                owed_results.push_back(r);
            end
            REQ_STOP:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_on[i] && slot_id[i] == id)
                        slot_on[i] = 1'b0;
                r.kind   = KIND_STATUS;
                r.status = ST_OK;
                r.last   = 1'b1;
                owed_results.push_back(r);
            end
            REQ_TICK:
            begin
                now_ms = now_ms + 32'(step_ms);
                for (int i = 0; i < SLOTS; i++)
                begin
                    elapsed = now_ms - slot_sent[i];
                    if (n < MAX_OUT && slot_on[i] && elapsed >= slot_per[i])
                    begin
                        batch[n]         = '0;
                        batch[n].kind    = KIND_FRAME;
                        batch[n].status  = ST_OK;
                        batch[n].id      = slot_id[i];
                        batch[n].ext     = slot_ext[i];
                        batch[n].len     = slot_len[i];
                        batch[n].payload = slot_pay[i];
                        batch[n].slot    = 2'(i);
                        slot_sent[i]     = now_ms;
                        n++;
                    end
                end
                if (n > 0)
                    batch[n-1].last = 1'b1;
                for (int k = 0; k < n; k++)
                    owed_results.push_back(batch[k]);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_req(input logic [1:0] req, input logic [28:0] id,
                            input logic ext, input logic [3:0] len,
                            input logic [63:0] pay, input logic [31:0] period);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start         <= 1'b1;
        req_type      <= req;
        frame_id      <= id;
        extended      <= ext;
        length_code   <= len;
        payload       <= pay;
        repeat_period <= period;
        do
            @(posedge clk);
        while (busy);
        schedule_request(req, id, ext, len, pay, period);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        step_ms    = value;
    endtask

    task automatic test_idle_requests();
        send_req(REQ_TICK, '0, 1'b0, '0, '0, '0);
        send_req(REQ_UNUSED, ID_MAX, 1'b1, 4'hF, '1, '1);
        send_req(REQ_STOP, 29'd5, 1'b0, '0, '0, '0);
    endtask

    task automatic test_slot_fill();
        send_req(REQ_START, '0, 1'b0, 4'h0, 64'h0, 32'h0);
        send_req(REQ_START, ID_MAX, 1'b1, 4'hF, '1, 32'hFFFF_FFFF);
        send_req(REQ_START, 29'h0AAA_AAAA, 1'b0, 4'h5, 64'h0123_4567_89AB_CDEF, 32'd20);
        send_req(REQ_START, 29'h1555_5555, 1'b1, 4'hA, 64'hFEDC_BA98_7654_3210, 32'd10);
        send_req(REQ_START, 29'h123, 1'b0, 4'h8, 64'h5555_AAAA_5555_AAAA, 32'd1);
        send_req(REQ_TICK, '0, 1'b0, '0, '0, '0);
        // same id, other extended flag: reuses the slot
        send_req(REQ_START, ID_MAX, 1'b0, 4'h3, 64'hAAAA_5555_AAAA_5555, 32'd0);
        send_req(REQ_TICK, '0, 1'b0, '0, '0, '0);
        send_req(REQ_STOP, ID_MAX, 1'b0, '0, '0, '0);
        send_req(REQ_START, 29'h77, 1'b1, 4'h7, 64'h8000_0000_0000_0001, 32'd5);
        send_req(REQ_TICK, '0, 1'b0, '0, '0, '0);
        send_req(REQ_STOP, 29'h0AAA_AAAA, 1'b0, '0, '0, '0);
        send_req(REQ_STOP, '0, 1'b0, '0, '0, '0);
        send_req(REQ_STOP, '0, 1'b0, '0, '0, '0);
        send_req(REQ_TICK, '0, 1'b0, '0, '0, '0);
    endtask

    task automatic test_random_traffic(input logic [STEP_W-1:0] step, input int count);
        int          pick;
        int          sel;
        int          done;
        logic [1:0]  req;
        logic [28:0] id;
        logic [31:0] period;
        write_step(step);
        id_pool[$urandom_range(2, POOL_SIZE - 1)] = 29'($urandom);
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            id   = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            sel  = $urandom_range(0, 9);
            if (sel < 7)
                period = $urandom_range(0, 4 * int'(step) + 3);
            else if (sel == 7)
                period = '0;
            else if (sel == 8)
                period = $urandom;
            else
                period = 32'hFFFF_FFFF;
            if (pick < 45)
            begin
                req = REQ_START;
                if (pick < 8)
                    id = 29'($urandom);
            end
            else if (pick < 60)
            begin
                req = REQ_STOP;
                sel = $urandom_range(0, SLOTS - 1);
                if (pick < 52 && slot_on[sel])
                    id = slot_id[sel];
            end
            else if (pick < 63)
                req = REQ_UNUSED;
            else
                req = REQ_TICK;
            send_req(req, id, 1'($urandom), 4'($urandom), {$urandom, $urandom}, period);
            if (req != REQ_UNUSED)
                done++;
        end
    endtask

    always @(posedge clk)
    begin
        if (result_valid)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d", result_kind, out_slot);
                mismatches++;
            end
            else
            begin
                head = owed_results.pop_front();
                if (result_kind !== head.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", head.kind, result_kind);
                    mismatches++;
                end
                if (status !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, status);
                    mismatches++;
                end
                if (out_id !== head.id)
                begin
                    $error("out_id: expected %h, got %h", head.id, out_id);
                    mismatches++;
                end
                if (out_extended !== head.ext)
                begin
                    $error("out_extended: expected %0d, got %0d", head.ext, out_extended);
                    mismatches++;
                end
                if (out_length !== head.len)
                begin
                    $error("out_length: expected %0d, got %0d", head.len, out_length);
                    mismatches++;
                end
                if (out_payload !== head.payload)
                begin
                    $error("out_payload: expected %h, got %h", head.payload, out_payload);
                    mismatches++;
                end
                if (out_slot !== head.slot)
                begin
                    $error("out_slot: expected %0d, got %0d", head.slot, out_slot);
                    mismatches++;
                end
                if (last !== head.last)
                begin
                    $error("last: expected %0d, got %0d", head.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_on[i]   = 1'b0;
            slot_id[i]   = '0;
            slot_ext[i]  = 1'b0;
            slot_len[i]  = '0;
            slot_pay[i]  = '0;
            slot_per[i]  = '0;
            slot_sent[i] = '0;
        end
        now_ms  = '0;
        step_ms = STEP_RESET;
        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = 29'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_slot_fill();
        test_random_traffic(10'd1023, 26);
        test_random_traffic(10'd0, 26);
        test_random_traffic(10'd1, 26);
        test_random_traffic(10'd1000, 26);
        test_random_traffic(10'($urandom_range(2, 999)), 26);
        drain();
        if (mismatches == 0 && owed_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/cps_pkg.sv
src/cps_front.sv
src/cps_back.sv
src/can_periodic_frame_scheduler_top.sv
sim/testbench.sv
